// ===== rtl/ftvm_pkg.sv =====
// ftvm_pkg: shared constants, types and state encoding for face_to_vertex_mean
// no dependencies
package ftvm_pkg;
  localparam int MaxFaces   = 16;
  localparam int ValueWidth = 32;
  localparam int NumQ       = 7;
  localparam int CntWidth   = $clog2(MaxFaces + 1);
  localparam int SumWidth   = ValueWidth + $clog2(MaxFaces);
  localparam int QuoWidth   = SumWidth;
  localparam int StepWidth  = $clog2(QuoWidth + 1);

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic signed [SumWidth-1:0]   sum_t;
  typedef logic [CntWidth-1:0]          count_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accum;     // add the accepted face when there is room
    logic div_start; // load dividers
    logic div_step;  // one quotient bit
    logic clear;     // result taken, clear sums
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // this step produces the final bit
  } ctrl_status_t;
endpackage

// ===== rtl/ftvm_if.sv =====
// ftvm_if: valid/ready channel interfaces for face and mean beats
// depends on ftvm_pkg
interface ftvm_face_if;
  logic                   valid;
  logic                   ready;
  ftvm_pkg::value_t       face_source;
  ftvm_pkg::value_t       face_doublet;
  ftvm_pkg::value_t       face_vel_x;
  ftvm_pkg::value_t       face_vel_y;
  ftvm_pkg::value_t       face_vel_z;
  ftvm_pkg::value_t       face_pressure_coeff;
  ftvm_pkg::value_t       face_transpiration;
  logic                   last_face;
  modport source (output valid, face_source, face_doublet, face_vel_x, face_vel_y,
                  face_vel_z, face_pressure_coeff, face_transpiration, last_face,
                  input ready);
  modport sink (input valid, face_source, face_doublet, face_vel_x, face_vel_y,
                face_vel_z, face_pressure_coeff, face_transpiration, last_face,
                output ready);
endinterface

interface ftvm_mean_if;
  logic                   valid;
  logic                   ready;
  ftvm_pkg::value_t       mean_source;
  ftvm_pkg::value_t       mean_doublet;
  ftvm_pkg::value_t       mean_vel_x;
  ftvm_pkg::value_t       mean_vel_y;
  ftvm_pkg::value_t       mean_vel_z;
  ftvm_pkg::value_t       mean_pressure_coeff;
  ftvm_pkg::value_t       mean_transpiration;
  logic [4:0]             face_count;
  logic                   too_many_faces;
  modport source (output valid, mean_source, mean_doublet, mean_vel_x, mean_vel_y,
                  mean_vel_z, mean_pressure_coeff, mean_transpiration, face_count,
                  too_many_faces, input ready);
  modport sink (input valid, mean_source, mean_doublet, mean_vel_x, mean_vel_y,
                mean_vel_z, mean_pressure_coeff, mean_transpiration, face_count,
                too_many_faces, output ready);
endinterface

// ===== rtl/ftvm_ctrl.sv =====
// ftvm_ctrl: controller state machine (accumulate, divide, present result)
// depends on ftvm_pkg
module ftvm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  ftvm_pkg::ctrl_status_t status,
  output ftvm_pkg::ctrl_cmd_t    cmd
);
  import ftvm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACCUM;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_ACCUM: begin
        in_ready  = 1'b1;
        cmd.accum = in_valid;
        if (in_valid && in_last) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end
endmodule

// ===== rtl/ftvm_dp.sv =====
// ftvm_dp: running sums, face count and seven shared-step restoring dividers
// depends on ftvm_pkg
module ftvm_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  ftvm_pkg::ctrl_cmd_t    cmd,
  output ftvm_pkg::ctrl_status_t status,
  input  ftvm_pkg::value_t       face_val [ftvm_pkg::NumQ],
  output ftvm_pkg::value_t       mean_val [ftvm_pkg::NumQ],
  output logic [4:0]             face_count,
  output logic                   too_many_faces
);
  import ftvm_pkg::*;

  sum_t                   sum [NumQ];
  count_t                 faces_seen;
  logic                   dropped_flag;
  logic [QuoWidth-1:0]    quo [NumQ];   // magnitude shifts out, quotient in
  logic [CntWidth:0]      rem [NumQ];
  logic                   neg [NumQ];
  logic [StepWidth-1:0]   step;
  logic                   room;

  assign room = faces_seen < count_t'(MaxFaces);
  assign status.div_last = step == StepWidth'(QuoWidth - 1);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      faces_seen   <= '0;
      dropped_flag <= 1'b0;
      for (int i = 0; i < NumQ; i++) sum[i] <= '0;
    end else if (cmd.accum) begin
      if (room) begin
        faces_seen <= faces_seen + count_t'(1);
        for (int i = 0; i < NumQ; i++)
          sum[i] <= sum[i] + SumWidth'(face_val[i]);
      end else begin
        dropped_flag <= 1'b1;
      end
    end
  end

  // final sums including the last face when there is room, used at divider load
  sum_t   sum_fin [NumQ];
  always_comb begin
    for (int i = 0; i < NumQ; i++)
      sum_fin[i] = room ? sum[i] + SumWidth'(face_val[i]) : sum[i];
  end

  // restoring division on magnitudes, one quotient bit per cycle
  logic [CntWidth:0] trial [NumQ];
  always_comb begin
    for (int i = 0; i < NumQ; i++)
      trial[i] = {rem[i][CntWidth-1:0], quo[i][QuoWidth-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      step <= '0;
      for (int i = 0; i < NumQ; i++) begin
        neg[i] <= sum_fin[i][SumWidth-1];
        quo[i] <= sum_fin[i][SumWidth-1] ? QuoWidth'(-sum_fin[i]) : QuoWidth'(sum_fin[i]);
        rem[i] <= '0;
      end
    end else if (cmd.div_step) begin
      step <= step + StepWidth'(1);
      for (int i = 0; i < NumQ; i++) begin
        if (trial[i] >= {1'b0, faces_seen}) begin
          rem[i] <= trial[i] - {1'b0, faces_seen};
          quo[i] <= {quo[i][QuoWidth-2:0], 1'b1};
        end else begin
          rem[i] <= trial[i];
          quo[i] <= {quo[i][QuoWidth-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumQ; i++)
      mean_val[i] = neg[i] ? ValueWidth'(-quo[i]) : ValueWidth'(quo[i]);
  end

  // faces_seen holds the final count once the last face is in
  assign face_count     = 5'(faces_seen);
  assign too_many_faces = dropped_flag;
endmodule

// ===== rtl/face_to_vertex_mean_top.sv =====
// face_to_vertex_mean_top: top level joining controller and datapath
// depends on ftvm_pkg, ftvm_if, ftvm_ctrl, ftvm_dp
//
// Averages seven signed Q15.16 face quantities onto a vertex. One face beat
// is taken per cycle while accumulating; faces past the sixteenth are
// dropped and reported in too_many_faces. The beat with last_face set closes
// the vertex: seven restoring dividers then run in parallel, one quotient bit
// per cycle over the 36-bit sum magnitude, and face input is held off until
// the mean beat is taken. Means are truncated toward zero.
module face_to_vertex_mean_top (
  input logic  clk,
  input logic  rst,
  ftvm_face_if.sink   face_in,
  ftvm_mean_if.source mean_out
);
  import ftvm_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  value_t       face_val [NumQ];
  value_t       mean_val [NumQ];

  // quantities in a fixed lane order
  assign face_val[0] = face_in.face_source;
  assign face_val[1] = face_in.face_doublet;
  assign face_val[2] = face_in.face_vel_x;
  assign face_val[3] = face_in.face_vel_y;
  assign face_val[4] = face_in.face_vel_z;
  assign face_val[5] = face_in.face_pressure_coeff;
  assign face_val[6] = face_in.face_transpiration;

  ftvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (face_in.valid),
    .in_last   (face_in.last_face),
    .in_ready  (face_in.ready),
    .out_valid (mean_out.valid),
    .out_ready (mean_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ftvm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .face_val       (face_val),
    .mean_val       (mean_val),
    .face_count     (mean_out.face_count),
    .too_many_faces (mean_out.too_many_faces)
  );

  assign mean_out.mean_source         = mean_val[0];
  assign mean_out.mean_doublet        = mean_val[1];
  assign mean_out.mean_vel_x          = mean_val[2];
  assign mean_out.mean_vel_y          = mean_val[3];
  assign mean_out.mean_vel_z          = mean_val[4];
  assign mean_out.mean_pressure_coeff = mean_val[5];
  assign mean_out.mean_transpiration  = mean_val[6];
endmodule
